@@ design/bhac_pkg.sv @@
// Package for the button hold action classifier.
// Holds widths, codes, beep timing constants and the shared types.
// No dependencies.
package bhac_pkg;

    localparam int STAGE_COUNT_DEF = 6;
    localparam int TIMER_BITS_DEF  = 16;

    localparam int STAGE_REGS = 5;
    localparam int THR_W      = 16;
    localparam int STAGE_W    = 3;
    localparam int CODE_W     = 3;
    localparam int CMD_W      = 2;
    localparam int BEEP_W     = 10;
    localparam int LEFT_W     = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = ADDR_W - 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POWERUP = 2'd3;

    localparam logic [CODE_W-1:0] REQ_ADV_MODE      = 3'd0;
    localparam logic [CODE_W-1:0] REQ_ID_MODE       = 3'd1;
    localparam logic [CODE_W-1:0] REQ_RECOVERY      = 3'd2;
    localparam logic [CODE_W-1:0] REQ_DFU           = 3'd3;
    localparam logic [CODE_W-1:0] REQ_FACTORY_RESET = 3'd4;
    localparam logic [CODE_W-1:0] REQ_RINGING_STOP  = 3'd5;

    // highest stage whose release carries a request
    localparam logic [STAGE_W-1:0] LAST_REQ_STAGE = 3'd4;

    localparam logic [BEEP_W-1:0] ON_SHORT = 10'd20;
    localparam logic [BEEP_W-1:0] ON_MID   = 10'd250;
    localparam logic [BEEP_W-1:0] ON_LONG  = 10'd1000;
    localparam logic [BEEP_W-1:0] OFF_TIME = 10'd100;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_MID   = 2'd1,
        KIND_LONG  = 2'd2
    } t_kind;

    typedef logic [STAGE_REGS-1:0][THR_W-1:0] t_thr_set;

    localparam t_thr_set THR_RESET = {16'd10000, 16'd7000, 16'd5000, 16'd3000, 16'd1000};

    typedef struct packed {
        logic              start;
        t_kind             kind;
        logic [LEFT_W-1:0] count;
    } t_beep_cmd;

endpackage

@@ design/bhac_if.sv @@
// Handshake interfaces for the input items and the result items.
// Depends on bhac_pkg.
interface bhac_in_if;
    import bhac_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic             ringing_active;
    logic             button_held;

    modport source (output valid, cmd, ringing_active, button_held, input ready);
    modport sink   (input valid, cmd, ringing_active, button_held, output ready);
endinterface

interface bhac_out_if;
    import bhac_pkg::*;
    logic               valid;
    logic               ready;
    logic               speaker_on;
    logic               request_valid;
    logic [CODE_W-1:0]  request_code;
    logic               holding;
    logic [STAGE_W-1:0] hold_stage;

    modport source (output valid, speaker_on, request_valid, request_code, holding,
                    hold_stage, input ready);
    modport sink   (input valid, speaker_on, request_valid, request_code, holding,
                    hold_stage, output ready);
endinterface

@@ design/bhac_apb.sv @@
// Threshold register file behind the APB-style configuration port.
// Depends on bhac_pkg.
module bhac_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhac_pkg::ADDR_W-1:0]  paddr,
    input  logic [bhac_pkg::DATA_W-1:0]  pwdata,
    output logic [bhac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bhac_pkg::t_thr_set           o_thr
);
    import bhac_pkg::*;

    t_thr_set         r_thr;
    t_thr_set         n_thr;
    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign o_thr   = r_thr;

    always_comb begin
        n_thr = r_thr;
        for (int i = 0; i < STAGE_REGS; i++) begin
            if (wr_en && reg_idx == IDX_W'(i)) begin
                n_thr[i] = pwdata[THR_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < STAGE_REGS; i++) begin
            if (reg_idx == IDX_W'(i)) begin
                prdata = DATA_W'(r_thr[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else begin
            r_thr <= n_thr;
        end
    end

endmodule

@@ design/bhac_hold.sv @@
// Hold timer, stage tracking and request decode for one item.
// Depends on bhac_pkg; drives the beep sequencer through t_beep_cmd.
module bhac_hold #(
    parameter int STAGE_COUNT = bhac_pkg::STAGE_COUNT_DEF,
    parameter int TIMER_BITS  = bhac_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bhac_pkg::CMD_W-1:0]    i_cmd,
    input  logic                          i_ringing,
    input  logic                          i_held,
    input  bhac_pkg::t_thr_set            i_thr,
    output bhac_pkg::t_beep_cmd           o_beep,
    output logic                          o_req_valid,
    output logic [bhac_pkg::CODE_W-1:0]   o_req_code,
    output logic                          o_holding,
    output logic [bhac_pkg::STAGE_W-1:0]  o_stage
);
    import bhac_pkg::*;

    localparam int CMP_W = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

    logic                  r_active;
    logic                  n_active;
    logic [STAGE_W-1:0]    r_stage;
    logic [STAGE_W-1:0]    n_stage;
    logic [TIMER_BITS-1:0] r_timer;
    logic [TIMER_BITS-1:0] n_timer;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [STAGE_W-1:0]    next_stage;
    logic                  thr_found;
    logic [THR_W-1:0]      thr_sel;

    assign timer_inc  = (r_timer != '1) ? r_timer + 1'b1 : r_timer;
    assign next_stage = r_stage + 1'b1;

    always_comb begin
        thr_found = 1'b0;
        thr_sel   = '0;
        for (int i = 0; i < STAGE_REGS; i++) begin
            if (next_stage == STAGE_W'(i + 1)) begin
                thr_found = 1'b1;
                thr_sel   = i_thr[i];
            end
        end
    end

    always_comb begin
        n_active    = r_active;
        n_stage     = r_stage;
        n_timer     = r_timer;
        o_beep      = '{start: 1'b0, kind: KIND_SHORT, count: '0};
        o_req_valid = 1'b0;
        o_req_code  = REQ_ADV_MODE;
        case (i_cmd)
            CMD_TICK: begin
                if (r_active) begin
                    n_timer = timer_inc;
                    if (r_stage < LAST_STAGE && thr_found
                        && CMP_W'(timer_inc) >= CMP_W'(thr_sel)) begin
                        n_stage      = next_stage;
                        o_beep.start = 1'b1;
                        if (next_stage == LAST_STAGE) begin
                            o_beep.kind  = KIND_MID;
                            o_beep.count = LEFT_W'(1);
                        end else begin
                            o_beep.kind  = KIND_SHORT;
                            o_beep.count = LEFT_W'(next_stage);
                        end
                    end
                end
            end
            CMD_PRESS: begin
                n_active = 1'b1;
                n_stage  = '0;
                n_timer  = '0;
                if (i_ringing) begin
                    o_req_valid = 1'b1;
                    o_req_code  = REQ_RINGING_STOP;
                end
            end
            CMD_RELEASE: begin
                if (r_active && r_stage != '0 && r_stage <= LAST_REQ_STAGE
                    && r_stage < LAST_STAGE) begin
                    o_req_valid = 1'b1;
                    o_req_code  = CODE_W'(r_stage - 1'b1);
                end
                n_active = 1'b0;
                n_stage  = '0;
                n_timer  = '0;
            end
            CMD_POWERUP: begin
                if (i_held) begin
                    o_beep      = '{start: 1'b1, kind: KIND_LONG, count: LEFT_W'(1)};
                    o_req_valid = 1'b1;
                    o_req_code  = REQ_FACTORY_RESET;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    assign o_holding = n_active;
    assign o_stage   = n_active ? n_stage : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_stage  <= '0;
            r_timer  <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_stage  <= n_stage;
            r_timer  <= n_timer;
        end
    end

endmodule

@@ design/bhac_beep.sv @@
// Beep pattern sequencer: on/off phase timing and beep count.
// Depends on bhac_pkg; started by bhac_hold.
module bhac_beep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_tick,
    input  bhac_pkg::t_beep_cmd  i_start,
    output logic                 o_speaker
);
    import bhac_pkg::*;

    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic              r_on;
    logic              n_on;
    logic [BEEP_W-1:0] r_ptimer;
    logic [BEEP_W-1:0] n_ptimer;
    t_kind             r_kind;
    t_kind             n_kind;
    logic [BEEP_W-1:0] ptimer_inc;
    logic [BEEP_W-1:0] on_limit;

    assign ptimer_inc = r_ptimer + 1'b1;

    always_comb begin
        case (r_kind)
            KIND_MID:  on_limit = ON_MID;
            KIND_LONG: on_limit = ON_LONG;
            default:   on_limit = ON_SHORT;
        endcase
    end

    always_comb begin
        n_left   = r_left;
        n_on     = r_on;
        n_ptimer = r_ptimer;
        n_kind   = r_kind;
        if (i_tick) begin
            if (r_left == '0) begin
                n_on     = 1'b0;
                n_ptimer = '0;
            end else begin
                n_ptimer = ptimer_inc;
                if (r_on) begin
                    if (ptimer_inc >= on_limit) begin
                        n_on     = 1'b0;
                        n_ptimer = '0;
                    end
                end else if (ptimer_inc >= OFF_TIME) begin
                    n_left   = r_left - 1'b1;
                    n_ptimer = '0;
                    n_on     = (r_left != LEFT_W'(1));
                end
            end
        end
        // a new pattern replaces whatever is playing
        if (i_start.start) begin
            n_kind   = i_start.kind;
            n_left   = i_start.count;
            n_ptimer = '0;
            n_on     = (i_start.count != '0);
        end
    end

    assign o_speaker = n_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_on     <= 1'b0;
            r_ptimer <= '0;
            r_kind   <= KIND_SHORT;
        end else if (i_step) begin
            r_left   <= n_left;
            r_on     <= n_on;
            r_ptimer <= n_ptimer;
            r_kind   <= n_kind;
        end
    end

endmodule

@@ design/button_hold_action_classifier.sv @@
// Top level of the button hold action classifier: input register, hold and
// beep logic, result register. Depends on bhac_pkg, bhac_if, bhac_apb,
// bhac_hold and bhac_beep.
//
//   port     dir  handshake             payload
//   i_in     in   valid/ready           cmd, ringing_active, button_held
//   o_res    out  valid/ready           speaker_on, request_valid, request_code,
//                                       holding, hold_stage
//   apb      in   psel/penable/pready   paddr, pwdata, prdata (stageN_ms at 4*N-4)
//
// One item per cycle sustained while o_res is not stalled; a result passes
// through the input register and then the result register before it is
// shown on o_res.
// Every item gives exactly one result transfer.
// Reset is synchronous, active low; thresholds return to their defaults.
// A stalled o_res holds its result while the input register still takes
// one more transfer; i_in.ready drops only when both registers are full.
module button_hold_action_classifier #(
    parameter int STAGE_COUNT = bhac_pkg::STAGE_COUNT_DEF,
    parameter int TIMER_BITS  = bhac_pkg::TIMER_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bhac_in_if.sink                      i_in,
    bhac_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhac_pkg::ADDR_W-1:0]  paddr,
    input  logic [bhac_pkg::DATA_W-1:0]  pwdata,
    output logic [bhac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import bhac_pkg::*;

    logic               r_in_vld;
    logic [CMD_W-1:0]   r_cmd;
    logic               r_ring;
    logic               r_held;
    logic               r_out_vld;
    logic               r_speaker;
    logic               r_req_valid;
    logic [CODE_W-1:0]  r_req_code;
    logic               r_holding;
    logic [STAGE_W-1:0] r_stage;

    logic               advance;
    t_thr_set           thr;
    t_beep_cmd          beep_cmd;
    logic               speaker;
    logic               req_valid;
    logic [CODE_W-1:0]  req_code;
    logic               holding;
    logic [STAGE_W-1:0] stage;

    assign advance    = r_in_vld & (~r_out_vld | o_res.ready);
    assign i_in.ready = ~r_in_vld | advance;

    bhac_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (thr)
    );

    bhac_hold #(
        .STAGE_COUNT (STAGE_COUNT),
        .TIMER_BITS  (TIMER_BITS)
    ) u_hold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_cmd       (r_cmd),
        .i_ringing   (r_ring),
        .i_held      (r_held),
        .i_thr       (thr),
        .o_beep      (beep_cmd),
        .o_req_valid (req_valid),
        .o_req_code  (req_code),
        .o_holding   (holding),
        .o_stage     (stage)
    );

    bhac_beep u_beep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_tick    (r_cmd == CMD_TICK),
        .i_start   (beep_cmd),
        .o_speaker (speaker)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd  <= i_in.cmd;
            r_ring <= i_in.ringing_active;
            r_held <= i_in.button_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_speaker   <= speaker;
            r_req_valid <= req_valid;
            r_req_code  <= req_code;
            r_holding   <= holding;
            r_stage     <= stage;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.speaker_on    = r_speaker;
    assign o_res.request_valid = r_req_valid;
    assign o_res.request_code  = r_req_code;
    assign o_res.holding       = r_holding;
    assign o_res.hold_stage    = r_stage;

endmodule

@@ design/bhac_checker.sv @@
// Port-level checks on the result channel of the classifier, and the bind
// that attaches them to the top level. Depends on bhac_pkg.
module bhac_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_speaker_on,
    input logic                         i_request_valid,
    input logic [bhac_pkg::CODE_W-1:0]  i_request_code,
    input logic                         i_holding,
    input logic [bhac_pkg::STAGE_W-1:0] i_hold_stage
);
    import bhac_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_speaker_on)
            && $stable(i_request_valid) && $stable(i_request_code)
            && $stable(i_holding) && $stable(i_hold_stage))
        else $error("stalled result changed");

    a_idle_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_holding |-> i_hold_stage == '0)
        else $error("stage shown while not holding");

    a_factory_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_request_valid && i_request_code == REQ_FACTORY_RESET
            |-> i_speaker_on)
        else $error("factory reset without long beep");

    a_ring_stop_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_request_valid && i_request_code == REQ_RINGING_STOP
            |-> i_holding && i_hold_stage == '0)
        else $error("ringing stop outside a fresh press");

endmodule

bind button_hold_action_classifier bhac_checker u_bhac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_speaker_on    (o_res.speaker_on),
    .i_request_valid (o_res.request_valid),
    .i_request_code  (o_res.request_code),
    .i_holding       (o_res.holding),
    .i_hold_stage    (o_res.hold_stage)
);
